// ===== rtl/fclw_pkg.sv =====
// ----------------------------------------------------------------------------
// fclw_pkg
// Shared types and constants for the four-connected line walker.
// ----------------------------------------------------------------------------
package fclw_pkg;

   localparam int GRID_SIZE = 32;
   localparam int COORD_W   = 5;
   // steps in one line: at most 2 * (GRID_SIZE - 1)
   localparam int COUNT_W   = COORD_W + 1;
   // (1 + 2 * i) * d with i, d below GRID_SIZE
   localparam int PROD_W    = 2 * COORD_W + 1;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [PROD_W-1:0]  prod_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type cell_x;
      coord_type cell_y;
      logic      last_cell;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic last;
   } status_type;

   // saturate a coordinate to the grid
   function automatic coord_type clamp_coord(input coord_type v);
      coord_type c;
      c = v;
      if ({1'b0, v} >= COUNT_W'(GRID_SIZE)) begin
         c = COORD_W'(GRID_SIZE - 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/fclw_datapath.sv =====
// ----------------------------------------------------------------------------
// fclw_datapath
// Cell position, step decision terms and remaining step count of one line.
// ----------------------------------------------------------------------------
module fclw_datapath (
   input  logic                clock,
   input  fclw_pkg::req_type    req,
   input  fclw_pkg::ctrl_type   ctrl,
   output fclw_pkg::status_type status,
   output fclw_pkg::coord_type  cell_x,
   output fclw_pkg::coord_type  cell_y
);
   import fclw_pkg::*;

   coord_type x_ff, x_in;
   coord_type y_ff, y_in;
   coord_type adx_ff, adx_in;
   coord_type ady_ff, ady_in;
   logic      xneg_ff, xneg_in;
   logic      yneg_ff, yneg_in;
   prod_type  lhs_ff, lhs_in;
   prod_type  rhs_ff, rhs_in;
   count_type remain_ff, remain_in;

   coord_type sx, sy, ex, ey;
   coord_type dx, dy;

   // clamp the request and take the distances
   always_comb begin
      sx = clamp_coord(req.start_x);
      sy = clamp_coord(req.start_y);
      ex = clamp_coord(req.end_x);
      ey = clamp_coord(req.end_y);
      dx = (ex >= sx) ? (ex - sx) : (sx - ex);
      dy = (ey >= sy) ? (ey - sy) : (sy - ey);
   end

   // load a new line or advance one cell
   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      adx_in    = adx_ff;
      ady_in    = ady_ff;
      xneg_in   = xneg_ff;
      yneg_in   = yneg_ff;
      lhs_in    = lhs_ff;
      rhs_in    = rhs_ff;
      remain_in = remain_ff;
      if (ctrl.load) begin
         x_in      = sx;
         y_in      = sy;
         adx_in    = dx;
         ady_in    = dy;
         xneg_in   = ex < sx;
         yneg_in   = ey < sy;
         lhs_in    = PROD_W'(dy);
         rhs_in    = PROD_W'(dx);
         remain_in = COUNT_W'(dx) + COUNT_W'(dy);
      end else if (ctrl.step) begin
         // horizontal when (1+2ix)*ady < (1+2iy)*adx, else vertical
         if (lhs_ff < rhs_ff) begin
            x_in   = xneg_ff ? (x_ff - COORD_W'(1)) : (x_ff + COORD_W'(1));
            lhs_in = lhs_ff + PROD_W'({ady_ff, 1'b0});
         end else begin
            y_in   = yneg_ff ? (y_ff - COORD_W'(1)) : (y_ff + COORD_W'(1));
            rhs_in = rhs_ff + PROD_W'({adx_ff, 1'b0});
         end
         remain_in = remain_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      xneg_ff   <= xneg_in;
      yneg_ff   <= yneg_in;
      lhs_ff    <= lhs_in;
      rhs_ff    <= rhs_in;
      remain_ff <= remain_in;
   end

   assign status.last = (remain_ff == '0);
   assign cell_x      = x_ff;
   assign cell_y      = y_ff;

endmodule

// ===== rtl/fclw_controller.sv =====
// ----------------------------------------------------------------------------
// fclw_controller
// Sequences one line: load on request, then one cell per cycle to the end.
// ----------------------------------------------------------------------------
module fclw_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  fclw_pkg::status_type status,
   output fclw_pkg::ctrl_type   ctrl,
   output logic                busy,
   output logic                rsp_strobe
);
   import fclw_pkg::*;

   state_type state_ff, state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ctrl       = '0;
      busy       = 1'b0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            busy       = 1'b1;
            rsp_strobe = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end else begin
               ctrl.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/four_connected_line_walker_top.sv =====
// ----------------------------------------------------------------------------
// four_connected_line_walker_top
// Walks a 4-connected line between two grid cells, one cell per result.
//
//   channel   ports                     handshake
//   request   start, busy, req          taken when start high and busy low
//   result    rsp_strobe, rsp           one cell per cycle, no back-pressure
//
// A line of adx + ady + 1 cells (up to 63) is loaded from the request and
// then sent one cell per cycle; busy is high for exactly the cells emitted.
// The step decision uses running sums of 2*ady and 2*adx, so no multiplier.
// Reset returns the controller to idle; datapath registers are not reset.
// The receiver cannot stall: each cell is shown for a single cycle.
// ----------------------------------------------------------------------------
module four_connected_line_walker_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fclw_pkg::req_type req,
   output logic             rsp_strobe,
   output fclw_pkg::rsp_type rsp
);
   import fclw_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   coord_type  cell_x;
   coord_type  cell_y;

   fclw_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .ctrl       (ctrl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   fclw_datapath u_datapath (
      .clock  (clock),
      .req    (req),
      .ctrl   (ctrl),
      .status (status),
      .cell_x (cell_x),
      .cell_y (cell_y)
   );

   // drive the result
   always_comb begin
      rsp.cell_x    = cell_x;
      rsp.cell_y    = cell_y;
      rsp.last_cell = status.last;
   end

endmodule
